>>> sv/rws_pkg.sv
// Package for the round-trip-time window statistics block.
// Holds the field widths, marker constants and the default window size.
// Depends on nothing.
`timescale 1ns / 1ps

package rws_pkg;

    localparam int RTT_W      = 14;
    localparam int MIN_W      = 31;
    localparam int LOSS_W     = 7;
    localparam int DEV_W      = 16;
    localparam int WLEN_W     = 5;
    localparam int WINDOW_MAX_DEFAULT = 16;

    localparam logic [RTT_W-1:0] LOST_MARK   = 14'd10000;
    localparam logic [RTT_W-1:0] UNUSED_MARK = 14'd10001;
    localparam logic [RTT_W-1:0] MAX_RTT     = 14'd9999;
    localparam logic [MIN_W-1:0] NO_MIN      = 31'h7FFF_FFFF;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd4;
    localparam int PERCENT = 100;

endpackage

>>> sv/rtt_window_statistics.sv
// Top level of the round-trip-time window statistics block.
// Uses rws_pkg for widths and marker constants.
`timescale 1ns / 1ps

// Usage
// The slave channel (s_axis_*) takes one probe result per item: tdata holds rtt
// in bits 13:0, tuser holds the lost flag. The master channel (m_axis_*) gives
// one statistics item for every probe. The user writes the window length
// register through cfg_wen/cfg_wdata only while the block is idle; the block
// does not enforce this. Values of 0 act as 1, above WINDOW_MAX as WINDOW_MAX.
// Sequencer
// Every item runs through a sequencer that uses a shared shift-subtract
// divider. It walks the window for sum, count, min, max and loss, divides
// for the average, walks it again for squared deltas, divides, takes a
// square root two bits a step, divides for the loss percent, walks the
// jitter ring and divides once more. The deviation passes are skipped when
// fewer than two rtt values are in the window, and the jitter passes when
// the probe is lost or no earlier reply exists.
// Reset and stalls
// Reset marks all rtt slots unused, clears the jitter ring and the running
// extremes. A result waits in the output register while m_axis_tready is low;
// the next item is taken once the sequencer is idle and waits before output.
module rtt_window_statistics #(
    parameter int WINDOW_MAX = rws_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [rws_pkg::WLEN_W-1:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rtt [13:0], zeros above
    input  logic        s_axis_tuser,   // lost
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // probe_rtt[13:0], window_average[27:14], window_min[58:28],
    // window_max[72:59], loss_percent[79:73], deviation[95:80],
    // jitter_average[109:96], all_time_min[140:110], all_time_max[154:141]
    output logic [159:0] m_axis_tdata
);
    import rws_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int SUM_W = RTT_W + CNT_W;
    localparam int SQ_W  = 2 * RTT_W + CNT_W;
    localparam int DIV_W = 34;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SCAN, S_AVG_DIV, S_DEV_SCAN, S_DEV_DIV,
        S_SQRT, S_LOSS_DIV, S_JIT_SCAN, S_JIT_DIV, S_OUT
    } state_t;

    state_t state_reg;

    logic [RTT_W-1:0] rtt_ring [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] used_reg;
    logic [RTT_W-1:0] jit_ring_reg [WINDOW_MAX];

    logic [WLEN_W-1:0] wlen_reg;
    logic [IDX_W-1:0]  wslot_reg, slot_reg, idx_reg;
    logic [RTT_W-1:0]  prev_rtt_reg, held_jit_reg, v_reg;
    logic              prev_valid_reg, lost_reg;
    logic [MIN_W-1:0]  run_min_reg;
    logic [RTT_W-1:0]  run_max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg, lostn_reg;
    logic [RTT_W-1:0]  wmin_reg, wmax_reg, avg_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [LOSS_W-1:0] loss_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [159:0]      out_reg;
    logic              out_valid_reg;
    logic [LEN_W-1:0]  wl;

    // Shared shift-subtract divider: remainder, quotient, divisor, step count.
    logic [DIV_W-1:0] num_reg, quo_reg, rem_reg, den_reg;
    logic [5:0]       step_reg;
    logic [DIV_W:0]   rem_shift;
    // Square root: two bits per step.
    logic [DIV_W-1:0] sx_reg, sres_reg, sbit_reg;

    always_comb
    begin
        if (wlen_reg == '0)
            wl = LEN_W'(1);
        else if (LEN_W'(wlen_reg) > LEN_W'(WINDOW_MAX))
            wl = LEN_W'(WINDOW_MAX);
        else
            wl = LEN_W'(wlen_reg);
    end

    // Slot read view: an unused slot reads as the unused mark.
    logic [RTT_W-1:0] slot_val;
    logic [RTT_W-1:0] dlt;
    logic [2*RTT_W-1:0] dsq;
    logic             last_idx;
    always_comb
    begin
        slot_val = used_reg[idx_reg] ? rtt_ring[idx_reg] : UNUSED_MARK;
        dlt = (avg_reg >= slot_val) ? avg_reg - slot_val : slot_val - avg_reg;
        dsq = dlt * dlt;
        last_idx = (LEN_W'(idx_reg) + LEN_W'(1)) >= wl;
        rem_shift = {rem_reg, num_reg[DIV_W-1]};
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    logic [RTT_W-1:0] in_rtt;
    assign in_rtt = (s_axis_tdata[RTT_W-1:0] > MAX_RTT) ? MAX_RTT : s_axis_tdata[RTT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            rtt_ring[slot_reg] <= v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            for (int i = 0; i < WINDOW_MAX; i++)
                jit_ring_reg[i] <= '0;
            wlen_reg       <= WLEN_RESET;
            wslot_reg      <= '0;
            prev_rtt_reg   <= '0;
            prev_valid_reg <= 1'b0;
            held_jit_reg   <= '0;
            run_min_reg    <= NO_MIN;
            run_max_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                wlen_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        lost_reg <= s_axis_tuser;
                        v_reg <= s_axis_tuser ? LOST_MARK : in_rtt;
                        slot_reg <= (LEN_W'(wslot_reg) >= wl) ? '0 : wslot_reg;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    used_reg[slot_reg] <= 1'b1;
                    idx_reg <= '0;
                    sum_reg <= '0; count_reg <= '0; lostn_reg <= '0;
                    wmin_reg <= LOST_MARK; wmax_reg <= '0;
                    if (!lost_reg)
                    begin
                        if (run_min_reg > MIN_W'(v_reg)) run_min_reg <= MIN_W'(v_reg);
                        if (run_max_reg < v_reg) run_max_reg <= v_reg;
                    end
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (slot_val < LOST_MARK)
                    begin
                        sum_reg <= sum_reg + SUM_W'(slot_val);
                        count_reg <= count_reg + CNT_W'(1);
                        if (slot_val < wmin_reg) wmin_reg <= slot_val;
                        if (slot_val > wmax_reg) wmax_reg <= slot_val;
                    end
                    else if (slot_val == LOST_MARK)
                        lostn_reg <= lostn_reg + CNT_W'(1);
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last_idx)
                    begin
                        num_reg <= DIV_W'(sum_reg + ((slot_val < LOST_MARK) ? SUM_W'(slot_val) : '0));
                        den_reg <= DIV_W'(count_reg + ((slot_val < LOST_MARK) ? CNT_W'(1) : '0));
                        rem_reg <= '0; quo_reg <= '0; step_reg <= '0;
                        state_reg <= S_AVG_DIV;
                    end
                end
                S_AVG_DIV, S_DEV_DIV, S_LOSS_DIV, S_JIT_DIV:
                begin
                    if (step_reg == 6'(DIV_W))
                    begin
                        rem_reg <= '0; quo_reg <= '0; step_reg <= '0;
                        case (state_reg)
                            S_AVG_DIV:
                            begin
                                avg_reg <= lost_reg ? LOST_MARK :
                                           (den_reg == '0 ? '0 : RTT_W'(quo_reg));
                                idx_reg <= '0; sq_reg <= '0;
                                state_reg <= S_DEV_SCAN;
                            end
                            S_DEV_DIV:
                            begin
                                sx_reg <= quo_reg; sres_reg <= '0;
                                sbit_reg <= DIV_W'(1) << (DIV_W - 2);
                                state_reg <= S_SQRT;
                            end
                            S_LOSS_DIV:
                            begin
                                loss_reg <= LOSS_W'(quo_reg);
                                if (!lost_reg && prev_valid_reg)
                                begin
                                    jit_ring_reg[slot_reg] <= (v_reg >= prev_rtt_reg) ?
                                        v_reg - prev_rtt_reg : prev_rtt_reg - v_reg;
                                    idx_reg <= '0; sum_reg <= '0;
                                    state_reg <= S_JIT_SCAN;
                                end
                                else
                                begin
                                    if (lost_reg)
                                        jit_ring_reg[slot_reg] <= held_jit_reg;
                                    else
                                    begin
                                        prev_rtt_reg <= v_reg; prev_valid_reg <= 1'b1;
                                    end
                                    state_reg <= S_OUT;
                                end
                            end
                            default:
                            begin
                                held_jit_reg <= RTT_W'(quo_reg);
                                prev_rtt_reg <= v_reg; prev_valid_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        step_reg <= step_reg + 6'd1;
                        if (rem_shift >= {1'b0, den_reg})
                        begin
                            rem_reg <= DIV_W'(rem_shift - {1'b0, den_reg});
                            quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_shift[DIV_W-1:0];
                            quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                        end
                    end
                end
                S_DEV_SCAN:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        dev_reg <= '0;
                        num_reg <= DIV_W'(lostn_reg) * DIV_W'(PERCENT);
                        den_reg <= DIV_W'(wl);
                        state_reg <= S_LOSS_DIV;
                    end
                    else
                    begin
                        if (slot_val > '0 && slot_val < LOST_MARK)
                            sq_reg <= sq_reg + SQ_W'(dsq);
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (last_idx)
                        begin
                            num_reg <= DIV_W'(sq_reg + ((slot_val > '0 && slot_val < LOST_MARK)
                                       ? SQ_W'(dsq) : '0));
                            den_reg <= DIV_W'(count_reg);
                            state_reg <= S_DEV_DIV;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sbit_reg == '0)
                    begin
                        dev_reg <= DEV_W'(sres_reg);
                        num_reg <= DIV_W'(lostn_reg) * DIV_W'(PERCENT);
                        den_reg <= DIV_W'(wl);
                        state_reg <= S_LOSS_DIV;
                    end
                    else
                    begin
                        if (sx_reg >= sres_reg + sbit_reg)
                        begin
                            sx_reg <= sx_reg - (sres_reg + sbit_reg);
                            sres_reg <= (sres_reg >> 1) + sbit_reg;
                        end
                        else
                            sres_reg <= sres_reg >> 1;
                        sbit_reg <= sbit_reg >> 2;
                    end
                end
                S_JIT_SCAN:
                begin
                    sum_reg <= sum_reg + SUM_W'(jit_ring_reg[idx_reg]);
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last_idx)
                    begin
                        num_reg <= DIV_W'(sum_reg + SUM_W'(jit_ring_reg[idx_reg]));
                        den_reg <= DIV_W'(wl);
                        state_reg <= S_JIT_DIV;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= {5'd0, run_max_reg, run_min_reg, held_jit_reg, dev_reg,
                                    loss_reg, wmax_reg,
                                    (count_reg == '0) ? NO_MIN : MIN_W'(wmin_reg),
                                    avg_reg, v_reg};
                        out_valid_reg <= 1'b1;
                        wslot_reg <= (LEN_W'(slot_reg) + LEN_W'(1) >= wl) ? '0 :
                                     slot_reg + IDX_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> tb/rtt_window_statistics_tb.sv
// Self-checking testbench for the round-trip-time window statistics block.
// Depends on rws_pkg and rtt_window_statistics; holds its own statistics predictor.
`timescale 1ns / 1ps

module rtt_window_statistics_tb;
    import rws_pkg::*;

    // One statistics item as the block reports it, highest field first.
    typedef struct packed {
        logic [RTT_W-1:0]  all_time_max;
        logic [MIN_W-1:0]  all_time_min;
        logic [RTT_W-1:0]  jitter_average;
        logic [DEV_W-1:0]  deviation;
        logic [LOSS_W-1:0] loss_percent;
        logic [RTT_W-1:0]  window_max;
        logic [MIN_W-1:0]  window_min;
        logic [RTT_W-1:0]  window_average;
        logic [RTT_W-1:0]  probe_rtt;
    } stats_t;

    // Idling styles of the two stream sides.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int SLOTS = WINDOW_MAX_DEFAULT;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [WLEN_W-1:0]   cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;   // rtt [13:0], zeros above
    logic                s_axis_tuser;   // lost
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // probe_rtt, window_average, window_min, window_max, loss_percent,
    // deviation, jitter_average, all_time_min, all_time_max (lowest bit up)
    logic [159:0]        m_axis_tdata;

    rtt_window_statistics dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: a private copy of the rings, pointers and extremes.
    int unsigned rtt_slots [SLOTS];
    int unsigned jitter_slots [SLOTS];
    int unsigned next_slot;
    int unsigned last_reply;
    bit          have_reply;
    int unsigned jitter_hold;
    int unsigned ever_min;
    int unsigned ever_max;
    int unsigned window_setting;

    stats_t      pending_stats[$];
    int          error_count;
    idle_mode_t  idle_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // A generous bound on the whole run.
    initial
    begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    // Floor square root, one result bit per pass from the top down.
    function automatic int unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return int'(root);
    endfunction

    // Works out the statistics item for one probe and advances the predictor.
    task automatic predict_stats(input bit lost, input int unsigned rtt_in, output stats_t st);
        int unsigned wl, v, slot, sum, count, lost_n, wmin, wmax, avg, dev, d, js;
        longint unsigned sq;
        wl = window_setting;
        sum = 0; count = 0; lost_n = 0; wmin = NO_MIN; wmax = 0; dev = 0;
        // A zero window acts as one slot; anything above the ring acts as the ring.
        if (wl == 0)
            wl = 1;
        if (wl > SLOTS)
            wl = SLOTS;
        if (rtt_in > MAX_RTT)
            rtt_in = MAX_RTT;
        v = lost ? LOST_MARK : rtt_in;
        // After the window shrank, the write pointer may sit outside it.
        if (next_slot >= wl)
            next_slot = 0;
        slot = next_slot;
        rtt_slots[slot] = v;
        for (int i = 0; i < wl; i++)
        begin
            if (rtt_slots[i] < LOST_MARK)
            begin
                sum += rtt_slots[i];
                if (rtt_slots[i] < wmin) wmin = rtt_slots[i];
                if (rtt_slots[i] > wmax) wmax = rtt_slots[i];
                count++;
            end
            else if (rtt_slots[i] == LOST_MARK)
                lost_n++;
        end
        avg = lost ? LOST_MARK : (count != 0 ? sum / count : 0);
        if (!lost)
        begin
            if (ever_min > v) ever_min = v;
            if (ever_max < v) ever_max = v;
        end
        // Zero-valued slots count toward the divisor but add no squared delta.
        if (count > 1)
        begin
            sq = 0;
            for (int i = 0; i < wl; i++)
            begin
                if (rtt_slots[i] > 0 && rtt_slots[i] < LOST_MARK)
                begin
                    d = (avg >= rtt_slots[i]) ? avg - rtt_slots[i] : rtt_slots[i] - avg;
                    sq += longint'(d) * longint'(d);
                end
            end
            dev = floor_sqrt(sq / count);
        end
        if (!lost)
        begin
            if (have_reply)
            begin
                jitter_slots[slot] = (v >= last_reply) ? v - last_reply : last_reply - v;
                js = 0;
                for (int i = 0; i < wl; i++)
                    js += jitter_slots[i];
                jitter_hold = js / wl;
            end
            last_reply = v;
            have_reply = 1'b1;
        end
        else
            jitter_slots[slot] = jitter_hold;
        next_slot = slot + 1;
        if (next_slot >= wl)
            next_slot = 0;
        st.probe_rtt      = v[RTT_W-1:0];
        st.window_average = avg[RTT_W-1:0];
        st.window_min     = wmin[MIN_W-1:0];
        st.window_max     = wmax[RTT_W-1:0];
        st.loss_percent   = 7'((lost_n * PERCENT) / wl);
        st.deviation      = dev[DEV_W-1:0];
        st.jitter_average = jitter_hold[RTT_W-1:0];
        st.all_time_min   = ever_min[MIN_W-1:0];
        st.all_time_max   = ever_max[RTT_W-1:0];
    endtask

    // The receiver stalls at random according to the current idling style.
    always @(posedge clk)
    begin
        if (idle_mode == IDLE_RECEIVER)
            m_axis_tready <= ($urandom_range(99) >= 81);
        else if (idle_mode == IDLE_BOTH)
            m_axis_tready <= ($urandom_range(99) >= 9);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // Each accepted statistics item is checked against the oldest prediction.
    always @(posedge clk)
    begin
        stats_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = stats_t'(m_axis_tdata[$bits(stats_t)-1:0]);
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $realtime, got);
                error_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                compare_field("probe_rtt", want.probe_rtt, got.probe_rtt);
                compare_field("window_average", want.window_average, got.window_average);
                compare_field("window_min", want.window_min, got.window_min);
                compare_field("window_max", want.window_max, got.window_max);
                compare_field("loss_percent", want.loss_percent, got.loss_percent);
                compare_field("deviation", want.deviation, got.deviation);
                compare_field("jitter_average", want.jitter_average, got.jitter_average);
                compare_field("all_time_min", want.all_time_min, got.all_time_min);
                compare_field("all_time_max", want.all_time_max, got.all_time_max);
            end
        end
    end

    // Sends one probe. Sender gaps come first; tvalid stays high on return so
    // that back-to-back items need no drop in between.
    task automatic send_probe(input bit lost, input int unsigned rtt_in);
        stats_t st;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)
        begin
            while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 81 : 9))
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= lost;
        s_axis_tdata  <= {2'b00, rtt_in[RTT_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_stats(lost, rtt_in, st);
        pending_stats.push_back(st);
    endtask

    // Stops sending and waits for every predicted item, plus a short margin.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_window(input int unsigned value);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value[WLEN_W-1:0];
        @(posedge clk);
        cfg_wen   <= 1'b0;
        window_setting = value;
    endtask

    // Random rtt: mostly in range, sometimes the full field to hit the saturation.
    task automatic send_random_probe(input int lost_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            send_probe(1'b0, $urandom_range(16383));
        else if (r < 20)
            send_probe(1'b0, $urandom_range(20));
        else
            send_probe($urandom_range(99) < lost_pct, $urandom_range(MAX_RTT));
    endtask

    // Losses on an empty window, zero and largest times, saturation and zero slots.
    task automatic test_field_extremes();
        idle_mode = IDLE_NONE;
        send_probe(1'b1, 0);
        send_probe(1'b1, 16383);
        send_probe(1'b0, 0);
        send_probe(1'b0, MAX_RTT);
        send_probe(1'b0, 16383);
        send_probe(1'b0, 10000);
        send_probe(1'b0, 0);
        send_probe(1'b1, 5);
        send_probe(1'b0, 1);
        send_probe(1'b0, 8191);
    endtask

    // Window lengths at the edges, a shrink that strands the write pointer and
    // a regrow that brings stale slots back.
    task automatic test_window_lengths();
        write_window(16);
        repeat (5) send_probe(1'b0, $urandom_range(MAX_RTT));
        write_window(3);
        send_probe(1'b0, 100);
        send_probe(1'b1, 0);
        write_window(16);
        send_probe(1'b0, 200);
        write_window(1);
        send_probe(1'b0, 300);
        send_probe(1'b0, 9000);
        write_window(0);
        send_probe(1'b1, 0);
        send_probe(1'b0, 42);
        write_window(31);
        send_probe(1'b0, 7);
        send_probe(1'b1, 0);
        write_window(17);
        send_probe(1'b0, 1234);
    endtask

    // Random probes over several window lengths and every idling style.
    task automatic test_random_traffic();
        int unsigned wl;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(9))
                0:       wl = 0;
                1:       wl = $urandom_range(31, 17);
                2:       wl = 1;
                3:       wl = 16;
                default: wl = $urandom_range(16, 1);
            endcase
            write_window(wl);
            idle_mode = idle_mode_t'(phase % 4);
            for (int n = 0; n < 230; n++)
                send_random_probe((phase % 3 == 0) ? 50 : 15);
        end
    endtask

    // The sender holds off until every result is back, then resumes.
    task automatic test_pause_until_drained();
        idle_mode = IDLE_BOTH;
        write_window(WLEN_RESET);
        repeat (10) send_random_probe(20);
        drain_results();
        repeat (10) send_random_probe(20);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        idle_mode      = IDLE_NONE;
        error_count    = 0;
        window_setting = WLEN_RESET;
        next_slot = 0; last_reply = 0; have_reply = 1'b0; jitter_hold = 0;
        ever_min = NO_MIN; ever_max = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rtt_slots[i]    = UNUSED_MARK;
            jitter_slots[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_window_lengths();
        test_pause_until_drained();
        test_random_traffic();

        drain_results();
        repeat (250) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
sv/rws_pkg.sv
sv/rtt_window_statistics.sv
tb/rtt_window_statistics_tb.sv
